@@ hw/rtl/cfot_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cfot_pkg;

    // default geometry of the table
    localparam int DEF_NUM_CARDS      = 8192;
    localparam int DEF_CARD_UNITS_LOG = 6;

    // fixed field widths
    localparam int START_W = 19;
    localparam int END_W   = 20;
    localparam int CARD_W  = 13;
    localparam int NEXT_W  = 14;
    localparam int OBJ_W   = 26;
    localparam int BASE_W  = 45;
    localparam int ENTRY_W = 8;

    // command codes
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_QREAD,
        ST_QFIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [NEXT_W-1:0] next_card;
        logic [OBJ_W-1:0]  first_object;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/cfot_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cfot_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [18:0] object_start;
    logic [19:0] object_end;
    logic [12:0] card_index;

    modport source (
        output valid, command, object_start, object_end, card_index,
        input  ready
    );
    modport sink (
        input  valid, command, object_start, object_end, card_index,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/cfot_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cfot_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] next_card;
    logic [25:0] first_object;

    modport source (
        output valid, next_card, first_object,
        input  ready
    );
    modport sink (
        input  valid, next_card, first_object,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/card_first_object_table.sv @@
// card_first_object_table: block offset table with one signed byte per card
//
// i_in carries one transaction per item: command 0 records an object (start,
// end, first boundary card crossed), command 1 queries the first object of a
// card. o_out returns one transaction per item: next_card for a record,
// first_object for a query, the other field zero.
// i_cfg_we / i_cfg_data write segment_base; write it only while idle.
// items are worked one at a time through a single-port card memory:
//   record: one memory write per card filled
//   query: one memory read per hop; a table
//          laid down in address order needs at most log2(NUM_CARDS) hops
// an out-of-table record card writes no entry. a finished result sits in an
// output register, and the next item is accepted while it waits.
// if the receiver stalls, the output register holds, a second finished
// result waits in the sequencer and i_in.ready drops until the slot frees.
// reset clears the sequencer, the output valid and segment_base; card
// entries are not cleared and must be recorded before they are queried.
`timescale 1ns / 1ps
`default_nettype none

module card_first_object_table
    import cfot_pkg::*;
#(
    parameter int NUM_CARDS      = DEF_NUM_CARDS,
    parameter int CARD_UNITS_LOG = DEF_CARD_UNITS_LOG
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [BASE_W-1:0] i_cfg_data,
    cfot_in_if.sink                i_in,
    cfot_out_if.source             o_out
);

    // card address width
    localparam int CW = $clog2(NUM_CARDS);

    logic [BASE_W-1:0]  r_base;
    logic               r_out_valid;
    t_result            r_out;

    logic               w_res_valid;
    logic               w_res_ready;
    t_result            w_res;
    logic               w_mem_we;
    logic               w_mem_re;
    logic [CW-1:0]      w_mem_addr;
    logic [ENTRY_W-1:0] w_mem_wdata;
    logic [ENTRY_W-1:0] w_mem_rdata;

    // segment base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_data;
        end
    end

    // sequencer: record fill and query back-skip walk
    cfot_ctrl #(
        .NUM_CARDS      (NUM_CARDS),
        .CARD_UNITS_LOG (CARD_UNITS_LOG),
        .CW             (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_base      (r_base[OBJ_W-1:0]),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_mem_we    (w_mem_we),
        .o_mem_re    (w_mem_re),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .i_mem_rdata (w_mem_rdata)
    );

    // card entry memory, registered read
    cfot_mem #(
        .DEPTH (NUM_CARDS),
        .AW    (CW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    // output register, loads when empty or being drained
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.next_card    = r_out.next_card;
    assign o_out.first_object = r_out.first_object;

endmodule

`default_nettype wire

@@ hw/rtl/cfot_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cfot_mem
    import cfot_pkg::*;
#(
    parameter int DEPTH = DEF_NUM_CARDS,
    parameter int AW    = $clog2(DEF_NUM_CARDS)
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_addr,
    input  wire logic [ENTRY_W-1:0] i_wdata,
    output logic      [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cfot_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cfot_ctrl
    import cfot_pkg::*;
#(
    parameter int NUM_CARDS      = DEF_NUM_CARDS,
    parameter int CARD_UNITS_LOG = DEF_CARD_UNITS_LOG,
    parameter int CW             = $clog2(DEF_NUM_CARDS)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    cfot_in_if.sink                 i_in,
    input  wire logic [OBJ_W-1:0]   i_base,
    output logic                    o_res_valid,
    output t_result                 o_res,
    input  wire logic               i_res_ready,
    output logic                    o_mem_we,
    output logic                    o_mem_re,
    output logic      [CW-1:0]      o_mem_addr,
    output logic      [ENTRY_W-1:0] o_mem_wdata,
    input  wire logic [ENTRY_W-1:0] i_mem_rdata
);

    localparam int CUR_W = CW + 1;
    localparam int IDX_W = (CUR_W > CARD_W) ? CUR_W : CARD_W;
    localparam int DW    = (CW + CARD_UNITS_LOG > START_W) ? CW + CARD_UNITS_LOG : START_W;
    localparam int CMP_W = (CUR_W + CARD_UNITS_LOG > END_W) ? CUR_W + CARD_UNITS_LOG : END_W;
    localparam int OW    = (CW + CARD_UNITS_LOG > ENTRY_W) ? CW + CARD_UNITS_LOG : ENTRY_W;
    localparam int EXP_W = $clog2(CW + 1);

    t_state             r_state, n_state;
    logic [END_W-1:0]   r_end, n_end;
    logic [CUR_W-1:0]   r_cursor, n_cursor;
    logic [CUR_W-1:0]   r_grp, n_grp;
    logic [CUR_W-1:0]   r_ingrp, n_ingrp;
    logic [EXP_W-1:0]   r_exp, n_exp;
    logic [CW-1:0]      r_idx, n_idx;
    logic [OW-1:0]      r_off, n_off;
    t_result            r_res, n_res;

    logic [IDX_W-1:0]   w_card_ext;
    logic [CW-1:0]      w_card_addr;
    logic               w_card_out;
    logic [DW-1:0]      w_bound;
    logic [DW-1:0]      w_diff;
    logic [ENTRY_W-1:0] w_dist;
    logic               w_fill_go;
    logic [CUR_W-1:0]   w_ingrp_inc;
    logic [ENTRY_W-1:0] w_k;
    logic [CW-1:0]      w_step;
    logic               w_skip_out;
    logic [OW-1:0]      w_qbound;
    logic [OW-1:0]      w_v_ext;

    // record: distance from card boundary back to the object start
    assign w_card_ext  = IDX_W'(i_in.card_index);
    assign w_card_out  = (w_card_ext >= IDX_W'(NUM_CARDS));
    assign w_card_addr = w_card_out ? CW'(NUM_CARDS - 1) : w_card_ext[CW-1:0];
    assign w_bound     = DW'(w_card_addr) << CARD_UNITS_LOG;
    assign w_diff      = (w_bound >= DW'(i_in.object_start))
                       ? w_bound - DW'(i_in.object_start) : '0;
    assign w_dist      = (w_diff > DW'(127)) ? ENTRY_W'(127) : ENTRY_W'(w_diff);

    // fill continues while the cursor card starts inside the object
    assign w_fill_go   = (r_cursor < CUR_W'(NUM_CARDS))
                       && ((CMP_W'(r_cursor) << CARD_UNITS_LOG) < CMP_W'(r_end));
    assign w_ingrp_inc = r_ingrp + CUR_W'(1);

    // query: back-skip code -(k+1) steps back 2^k cards
    assign w_k        = ~i_mem_rdata;
    assign w_step     = CW'(1) << w_k;
    assign w_skip_out = (w_k >= ENTRY_W'(CW)) || (w_step > r_idx);
    assign w_qbound   = OW'(r_idx) << CARD_UNITS_LOG;
    assign w_v_ext    = OW'(i_mem_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end    <= n_end;
        r_cursor <= n_cursor;
        r_grp    <= n_grp;
        r_ingrp  <= n_ingrp;
        r_exp    <= n_exp;
        r_idx    <= n_idx;
        r_off    <= n_off;
        r_res    <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_end       = r_end;
        n_cursor    = r_cursor;
        n_grp       = r_grp;
        n_ingrp     = r_ingrp;
        n_exp       = r_exp;
        n_idx       = r_idx;
        n_off       = r_off;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_addr  = '0;
        o_mem_wdata = '0;
        o_res_valid = 1'b0;
        i_in.ready  = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.command == CMD_RECORD) begin
                        n_end = i_in.object_end;
                        if (w_card_out) begin
                            n_res.next_card    = NEXT_W'(i_in.card_index);
                            n_res.first_object = '0;
                            n_state            = ST_DONE;
                        end else begin
                            o_mem_we    = 1'b1;
                            o_mem_addr  = w_card_addr;
                            o_mem_wdata = w_dist;
                            n_cursor    = CUR_W'(w_card_addr) + CUR_W'(1);
                            n_exp       = '0;
                            n_grp       = CUR_W'(1);
                            n_ingrp     = '0;
                            n_state     = ST_FILL;
                        end
                    end else begin
                        // out-of-table query card clamps to the last card
                        o_mem_re   = 1'b1;
                        o_mem_addr = w_card_addr;
                        n_idx      = w_card_addr;
                        n_state    = ST_QREAD;
                    end
                end
            end
            ST_FILL: begin
                if (w_fill_go) begin
                    o_mem_we    = 1'b1;
                    o_mem_addr  = r_cursor[CW-1:0];
                    o_mem_wdata = ~ENTRY_W'(r_exp);
                    n_cursor    = r_cursor + CUR_W'(1);
                    if (w_ingrp_inc == r_grp) begin
                        n_ingrp = '0;
                        n_exp   = r_exp + EXP_W'(1);
                        n_grp   = r_grp << 1;
                    end else begin
                        n_ingrp = w_ingrp_inc;
                    end
                end else begin
                    n_res.next_card    = NEXT_W'(r_cursor);
                    n_res.first_object = '0;
                    n_state            = ST_DONE;
                end
            end
            ST_QREAD: begin
                if (i_mem_rdata[ENTRY_W-1]) begin
                    if (w_skip_out) begin
                        // skip would leave the table below card zero
                        n_res.next_card    = '0;
                        n_res.first_object = i_base;
                        n_state            = ST_DONE;
                    end else begin
                        n_idx      = r_idx - w_step;
                        o_mem_re   = 1'b1;
                        o_mem_addr = r_idx - w_step;
                    end
                end else begin
                    n_off   = (w_qbound >= w_v_ext) ? w_qbound - w_v_ext : '0;
                    n_state = ST_QFIN;
                end
            end
            ST_QFIN: begin
                n_res.next_card    = '0;
                n_res.first_object = i_base + OBJ_W'(r_off);
                n_state            = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire
